// ===== rtl/lprd_pkg.sv =====
// ----------------------------------------------------------------------------
// Length-prefixed request deframer package
// Shared constants, phase encoding and the per-beat response record.
// ----------------------------------------------------------------------------
package lprd_pkg;

   localparam int DEFAULT_LENGTH_WIDTH = 16;
   localparam int LENGTH_VALUE_W       = 16;

   localparam logic [7:0] SPACE_CHAR = 8'h20;
   localparam logic [7:0] DIGIT_0    = 8'h30;
   localparam logic [7:0] DIGIT_9    = 8'h39;

   localparam logic [1:0] KIND_DELIM  = 2'd0;
   localparam logic [1:0] KIND_METHOD = 2'd1;
   localparam logic [1:0] KIND_HEADER = 2'd2;
   localparam logic [1:0] KIND_BODY   = 2'd3;

   localparam logic [1:0] STATUS_BUSY  = 2'd0;
   localparam logic [1:0] STATUS_DONE  = 2'd1;
   localparam logic [1:0] STATUS_ERROR = 2'd2;

   typedef enum logic [7:0] {
      PH_METHOD = 8'b0000_0001,
      PH_HLEN   = 8'b0000_0010,
      PH_HEADER = 8'b0000_0100,
      PH_SEP    = 8'b0000_1000,
      PH_BLEN   = 8'b0001_0000,
      PH_BODY   = 8'b0010_0000,
      PH_DONE   = 8'b0100_0000,
      PH_ERROR  = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic [1:0]                field_kind;
      logic [7:0]                byte_out;
      logic                      field_last;
      logic                      length_valid;
      logic [LENGTH_VALUE_W-1:0] length_value;
      logic [1:0]                status;
   } rsp_type;

endpackage

// ===== rtl/lprd_req_if.sv =====
// ----------------------------------------------------------------------------
// Request byte channel
// Valid/ready channel carrying one raw request byte per beat.
// ----------------------------------------------------------------------------
interface lprd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

// ===== rtl/lprd_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one deframer result per beat.
// ----------------------------------------------------------------------------
interface lprd_rsp_if;
   import lprd_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [1:0]                field_kind;
   logic [7:0]                byte_out;
   logic                      field_last;
   logic                      length_valid;
   logic [LENGTH_VALUE_W-1:0] length_value;
   logic [1:0]                status;

   modport source (output valid, output field_kind, output byte_out, output field_last,
                   output length_valid, output length_value, output status, input ready);
   modport sink   (input valid, input field_kind, input byte_out, input field_last,
                   input length_valid, input length_value, input status, output ready);
endinterface

// ===== rtl/lprd_parser.sv =====
// ----------------------------------------------------------------------------
// Deframer parser
// Phase machine, length accumulator and byte countdown; one byte per advance.
// ----------------------------------------------------------------------------
module lprd_parser #(
   parameter int LENGTH_WIDTH = lprd_pkg::DEFAULT_LENGTH_WIDTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [7:0]        data_byte,
   output lprd_pkg::rsp_type rsp
);
   import lprd_pkg::*;

   // Lengths are reported on a 16-bit field, so the limit never exceeds 16 bits.
   localparam int ACC_W = (LENGTH_WIDTH >= LENGTH_VALUE_W) ? LENGTH_VALUE_W : LENGTH_WIDTH;

   phase_type        phase_ff, phase_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic             digits_seen_ff, digits_seen_in;
   logic [ACC_W-1:0] remaining_ff, remaining_in;

   logic [ACC_W+3:0] acc_next;
   logic             acc_overflow;
   logic             is_space;
   logic             is_digit;
   logic [1:0]       kind;
   logic             last;
   logic             lvalid;

   assign is_space = (data_byte == SPACE_CHAR);
   assign is_digit = (data_byte inside {[DIGIT_0:DIGIT_9]});

   // acc * 10 + digit; anything in the top four bits is above the limit.
   assign acc_next = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1)
                   + (ACC_W+4)'(data_byte[3:0]);
   assign acc_overflow = |acc_next[ACC_W+3:ACC_W];

   always_comb begin
      phase_in       = phase_ff;
      acc_in         = acc_ff;
      digits_seen_in = digits_seen_ff;
      remaining_in   = remaining_ff;
      kind           = KIND_DELIM;
      last           = 1'b0;
      lvalid         = 1'b0;
      case (phase_ff)
         PH_METHOD: begin
            if (is_space) begin
               last           = 1'b1;
               phase_in       = PH_HLEN;
               acc_in         = '0;
               digits_seen_in = 1'b0;
            end else begin
               kind = KIND_METHOD;
            end
         end
         PH_HLEN, PH_BLEN: begin
            if (is_space) begin
               if (!digits_seen_ff) begin
                  phase_in = PH_ERROR;
               end else begin
                  lvalid         = 1'b1;
                  remaining_in   = acc_ff;
                  acc_in         = '0;
                  digits_seen_in = 1'b0;
                  if (phase_ff == PH_HLEN) begin
                     phase_in = (acc_ff == '0) ? PH_SEP : PH_HEADER;
                  end else begin
                     phase_in = (acc_ff == '0) ? PH_DONE : PH_BODY;
                  end
               end
            end else if (is_digit) begin
               if (acc_overflow) begin
                  phase_in = PH_ERROR;
               end else begin
                  acc_in         = acc_next[ACC_W-1:0];
                  digits_seen_in = 1'b1;
               end
            end else begin
               phase_in = PH_ERROR;
            end
         end
         PH_HEADER: begin
            kind         = KIND_HEADER;
            remaining_in = remaining_ff - 1'b1;
            if (remaining_ff == ACC_W'(1)) begin
               last     = 1'b1;
               phase_in = PH_SEP;
            end
         end
         PH_SEP: begin
            phase_in       = PH_BLEN;
            acc_in         = '0;
            digits_seen_in = 1'b0;
         end
         PH_BODY: begin
            kind         = KIND_BODY;
            remaining_in = remaining_ff - 1'b1;
            if (remaining_ff == ACC_W'(1)) begin
               last     = 1'b1;
               phase_in = PH_DONE;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp.field_kind   = kind;
      rsp.byte_out     = data_byte;
      rsp.field_last   = last;
      rsp.length_valid = lvalid;
      rsp.length_value = lvalid ? LENGTH_VALUE_W'(acc_ff) : '0;
      if (phase_in == PH_DONE) begin
         rsp.status = STATUS_DONE;
      end else if (phase_in == PH_ERROR) begin
         rsp.status = STATUS_ERROR;
      end else begin
         rsp.status = STATUS_BUSY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_METHOD;
         acc_ff         <= '0;
         digits_seen_ff <= 1'b0;
         remaining_ff   <= '0;
      end else if (advance) begin
         phase_ff       <= phase_in;
         acc_ff         <= acc_in;
         digits_seen_ff <= digits_seen_in;
         remaining_ff   <= remaining_in;
      end
   end

endmodule

// ===== rtl/lprd_out_stage.sv =====
// ----------------------------------------------------------------------------
// Response output register
// Holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module lprd_out_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  lprd_pkg::rsp_type rsp,
   output logic              has_room,
   lprd_rsp_if.source        rsp_bus
);
   import lprd_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign has_room = !valid_ff || rsp_bus.ready;
   assign valid_in = load || (valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= rsp;
      end
   end

   assign rsp_bus.valid        = valid_ff;
   assign rsp_bus.field_kind   = data_ff.field_kind;
   assign rsp_bus.byte_out     = data_ff.byte_out;
   assign rsp_bus.field_last   = data_ff.field_last;
   assign rsp_bus.length_valid = data_ff.length_valid;
   assign rsp_bus.length_value = data_ff.length_value;
   assign rsp_bus.status       = data_ff.status;

endmodule

// ===== rtl/length_prefixed_request_deframer_core.sv =====
// ----------------------------------------------------------------------------
// Length-prefixed request deframer core
// Splits a byte stream of the form method, header length, header, separator,
// body length, body into tagged result beats, one result per input byte.
//
//   Channel   Dir   Beat content
//   req_bus   in    data_byte
//   rsp_bus   out   field_kind, byte_out, field_last, length_valid,
//                   length_value, status
//
// One byte per cycle sustained while rsp_bus takes results; rsp valid rises
// after the req beat passes the input register, then the result register.
// The rate is set by the phase update between the two registers.
// Reset is synchronous and returns the parser to the method phase.
// A stalled rsp_bus holds the result register; the input register takes a
// byte only if empty; req_bus.ready then stays low until the result moves on.
// ----------------------------------------------------------------------------
module length_prefixed_request_deframer_core #(
   parameter int LENGTH_WIDTH = lprd_pkg::DEFAULT_LENGTH_WIDTH
) (
   input logic        clock,
   input logic        reset,
   lprd_req_if.sink   req_bus,
   lprd_rsp_if.source rsp_bus
);
   import lprd_pkg::*;

   logic       req_valid_ff, req_valid_in;
   logic [7:0] req_byte_ff;
   logic       advance;
   logic       out_room;
   rsp_type    step_rsp;

   assign advance       = req_valid_ff && out_room;
   assign req_bus.ready = !req_valid_ff || advance;
   assign req_valid_in  = (req_bus.valid && req_bus.ready) || (req_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         req_byte_ff <= req_bus.data_byte;
      end
   end

   lprd_parser #(
      .LENGTH_WIDTH (LENGTH_WIDTH)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .data_byte (req_byte_ff),
      .rsp       (step_rsp)
   );

   lprd_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .load     (advance),
      .rsp      (step_rsp),
      .has_room (out_room),
      .rsp_bus  (rsp_bus)
   );

endmodule
